/* src/srrs_pkg.sv */
// shared types, codes and result builders for the sector read retry sequencer
`timescale 1ns / 1ps
`default_nettype none
package srrs_pkg;

	localparam int unsigned MAX_BLOCKS = 65535;
	localparam int unsigned BUF_DEPTH  = 4;

	typedef enum logic {
		FUNC_START = 1'b0,
		FUNC_RSP   = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_BATCH  = 2'd1,
		PH_SINGLE = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		KIND_REQ   = 2'd0,
		KIND_VALID = 2'd1,
		KIND_HOLE  = 2'd2,
		KIND_DONE  = 2'd3
	} kind_t;

	typedef enum logic {
		CFG_HOLE_CAP    = 1'b0,
		CFG_RETRY_LIMIT = 1'b1
	} cfg_idx_t;

	// input word layout, lowest field last
	typedef struct packed {
		logic [6:0]         pad;
		logic signed [31:0] rsp_error;
		logic [31:0]        rsp_blocks;
		logic               rsp_status;
		logic [15:0]        block_count;
		logic [31:0]        start_lsn;
	} in_data_t;

	// result word layout, lowest field last
	typedef struct packed {
		logic [6:0]         pad;
		logic signed [31:0] error_code;
		logic               fatal;
		logic [15:0]        hole_total;
		logic [15:0]        valid_total;
		logic [15:0]        mark_count;
		logic [15:0]        first_index;
		logic [15:0]        req_count;
		logic [31:0]        req_lsn;
	} out_data_t;

	typedef struct packed {
		kind_t     kind;
		out_data_t data;
		logic      last;
	} res_t;

	function automatic res_t mk_req(input logic [31:0] lsn, input logic [15:0] count);
		res_t r;
		r = '0;
		r.kind = KIND_REQ;
		r.data.req_lsn = lsn;
		r.data.req_count = count;
		return r;
	endfunction

	function automatic res_t mk_mark(input kind_t kind, input logic [15:0] first,
			input logic [15:0] count);
		res_t r;
		r = '0;
		r.kind = kind;
		r.data.first_index = first;
		r.data.mark_count = count;
		return r;
	endfunction

	function automatic res_t mk_done(input logic [15:0] valid, input logic [15:0] holes,
			input logic is_fatal, input logic signed [31:0] err);
		res_t r;
		r = '0;
		r.kind = KIND_DONE;
		r.data.valid_total = valid;
		r.data.hole_total = holes;
		r.data.fatal = is_fatal;
		r.data.error_code = is_fatal ? err : 32'sd0;
		return r;
	endfunction

endpackage
`default_nettype wire

/* src/sector_read_retry_sequencer.sv */
// top level: batch read, then per-sector retry sequencing with hole marking
// an accepted word is held in the input register, then its results are written into the result
//   buffer that drives m_*; the buffer write waits while the buffer lacks room for two results
// throughput: one input word per cycle while each word makes at most one result and m_tready
//   stays high; a word that makes two results (mark plus request or done) fills the four-entry
//   result buffer faster than the single result port drains it, so input then backs up
// reset (arst_n low): job state cleared to idle, buffers emptied, hole cap 65535, retry_limit 3
`timescale 1ns / 1ps
`default_nettype none
module sector_read_retry_sequencer
	import srrs_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	// input stream
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [119:0] s_tdata,  // start_lsn, block_count, rsp_status, rsp_blocks, rsp_error
	input  wire logic         s_tuser,  // func
	// result stream
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [151:0]      m_tdata,  // req_lsn, req_count, first_index, mark_count,
	                                    // valid_total, hole_total, fatal, error_code
	output logic [1:0]        m_tuser,  // kind
	output logic              m_tlast,  // last
	// configuration writes
	input  wire logic         cfg_wr_en,
	input  wire logic         cfg_index,
	input  wire logic [15:0]  cfg_wdata
);

	localparam int unsigned PTR_W = $clog2(BUF_DEPTH);
	localparam int unsigned CNT_W = $clog2(BUF_DEPTH + 1);

	// configuration registers
	logic [15:0] hole_cap_q;
	logic [3:0]  retry_limit_q;

	// input register stage
	logic     v_s1;
	in_data_t in_s1;
	logic     s_tuser_s1;
	func_t    func_s1;

	// job state
	phase_t      phase_q, phase_nxt;
	logic [31:0] base_q, base_nxt;
	logic [15:0] job_q, job_nxt;
	logic [15:0] cur_q, cur_nxt;
	logic [3:0]  att_q, att_nxt;
	logic [15:0] valid_q, valid_nxt;
	logic [15:0] hole_q, hole_nxt;

	// results of the word in the input register
	res_t       r0, r1;
	logic [1:0] n_res;
	logic       fire;

	// result buffer
	res_t             buf_q [BUF_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hole_cap_q    <= 16'hFFFF;
			retry_limit_q <= 4'd3;
		end else if (cfg_wr_en) begin
			case (cfg_idx_t'(cfg_index))
				CFG_HOLE_CAP:    hole_cap_q    <= cfg_wdata;
				CFG_RETRY_LIMIT: retry_limit_q <= cfg_wdata[3:0];
				default: ;
			endcase
		end
	end

	// the input register is consumed once the buffer has room for two results
	assign fire     = v_s1 && (cnt_q <= CNT_W'(BUF_DEPTH - 2));
	assign s_tready = !v_s1 || fire;
	assign func_s1  = func_t'(s_tuser_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			in_s1      <= in_data_t'(s_tdata);
			s_tuser_s1 <= s_tuser;
		end
	end

	// next-state and result logic for one word
	always_comb begin
		logic [15:0] prefix;
		logic [16:0] idx_inc;
		logic [15:0] vc_inc;
		logic [15:0] hc_inc;

		r0 = '0;
		r1 = '0;
		n_res = 2'd0;
		phase_nxt = phase_q;
		base_nxt = base_q;
		job_nxt = job_q;
		cur_nxt = cur_q;
		att_nxt = att_q;
		valid_nxt = valid_q;
		hole_nxt = hole_q;

		// batch answer clamped to the job size
		prefix = (in_s1.rsp_blocks > {16'd0, job_q}) ? job_q : in_s1.rsp_blocks[15:0];
		idx_inc = {1'b0, cur_q} + 17'd1;
		vc_inc = valid_q + 16'd1;
		hc_inc = hole_q + 16'd1;

		if (func_s1 == FUNC_START) begin
			// a start drops any running job without a done result
			base_nxt = in_s1.start_lsn;
			job_nxt = (32'(in_s1.block_count) > MAX_BLOCKS) ? 16'(MAX_BLOCKS) :
				in_s1.block_count;
			cur_nxt = 16'd0;
			att_nxt = 4'd0;
			valid_nxt = 16'd0;
			hole_nxt = 16'd0;
			phase_nxt = PH_BATCH;
			r0 = mk_req(in_s1.start_lsn, job_nxt);
			n_res = 2'd1;
		end else begin
			case (phase_q)
				PH_BATCH: begin
					if (prefix != 16'd0) begin
						valid_nxt = prefix;
					end
					if (in_s1.rsp_status) begin
						r1 = mk_done(valid_nxt, hole_q, 1'b1, in_s1.rsp_error);
						phase_nxt = PH_IDLE;
					end else if (prefix == job_q) begin
						r1 = mk_done(valid_nxt, hole_q, 1'b0, 32'sd0);
						phase_nxt = PH_IDLE;
					end else begin
						// a short batch leaves sectors for single reads
						cur_nxt = prefix;
						att_nxt = 4'd0;
						phase_nxt = PH_SINGLE;
						r1 = mk_req(base_q + {16'd0, prefix}, 16'd1);
					end
					if (prefix != 16'd0) begin
						r0 = mk_mark(KIND_VALID, 16'd0, prefix);
						n_res = 2'd2;
					end else begin
						r0 = r1;
						n_res = 2'd1;
					end
				end
				PH_SINGLE: begin
					if (in_s1.rsp_status) begin
						r0 = mk_done(valid_q, hole_q, 1'b1, in_s1.rsp_error);
						phase_nxt = PH_IDLE;
						n_res = 2'd1;
					end else if (in_s1.rsp_blocks == 32'd1) begin
						r0 = mk_mark(KIND_VALID, cur_q, 16'd1);
						valid_nxt = vc_inc;
						cur_nxt = idx_inc[15:0];
						n_res = 2'd2;
						if (idx_inc >= {1'b0, job_q}) begin
							r1 = mk_done(vc_inc, hole_q, 1'b0, 32'sd0);
							phase_nxt = PH_IDLE;
						end else begin
							att_nxt = 4'd0;
							r1 = mk_req(base_q + {16'd0, idx_inc[15:0]}, 16'd1);
						end
					end else if (att_q < retry_limit_q) begin
						// retry the same sector
						att_nxt = att_q + 4'd1;
						r0 = mk_req(base_q + {16'd0, cur_q}, 16'd1);
						n_res = 2'd1;
					end else begin
						// out of attempts: sector becomes a hole
						r0 = mk_mark(KIND_HOLE, cur_q, 16'd1);
						hole_nxt = hc_inc;
						cur_nxt = idx_inc[15:0];
						n_res = 2'd2;
						if (hc_inc >= hole_cap_q || idx_inc >= {1'b0, job_q}) begin
							r1 = mk_done(valid_q, hc_inc, 1'b0, 32'sd0);
							phase_nxt = PH_IDLE;
						end else begin
							att_nxt = 4'd0;
							r1 = mk_req(base_q + {16'd0, idx_inc[15:0]}, 16'd1);
						end
					end
				end
				default: ;  // response while idle is dropped
			endcase
		end

		if (n_res == 2'd1) begin
			r0.last = 1'b1;
		end
		if (n_res == 2'd2) begin
			r1.last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			base_q  <= '0;
			job_q   <= '0;
			cur_q   <= '0;
			att_q   <= '0;
			valid_q <= '0;
			hole_q  <= '0;
		end else if (fire) begin
			phase_q <= phase_nxt;
			base_q  <= base_nxt;
			job_q   <= job_nxt;
			cur_q   <= cur_nxt;
			att_q   <= att_nxt;
			valid_q <= valid_nxt;
			hole_q  <= hole_nxt;
		end
	end

	// result buffer: up to two pushes and one pop per cycle
	assign pop = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= fire ? wr_q + PTR_W'(n_res) : wr_q;
			rd_q  <= rd_q + PTR_W'(pop);
			cnt_q <= cnt_q + (fire ? CNT_W'(n_res) : CNT_W'(0)) - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (fire && n_res != 2'd0) begin
			buf_q[wr_q] <= r0;
		end
		if (fire && n_res == 2'd2) begin
			buf_q[wr_q + PTR_W'(1)] <= r1;
		end
	end

	assign m_tvalid = (cnt_q != '0);
	assign m_tdata  = buf_q[rd_q].data;
	assign m_tuser  = buf_q[rd_q].kind;
	assign m_tlast  = buf_q[rd_q].last;

endmodule
`default_nettype wire

/* src/srrs_checker.sv */
// port-level checks for the sector read retry sequencer, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module srrs_checker
	import srrs_pkg::*;
(
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         m_tvalid,
	input wire logic         m_tready,
	input wire logic [151:0] m_tdata,
	input wire logic [1:0]   m_tuser,
	input wire logic         m_tlast
);

	out_data_t od;
	assign od = out_data_t'(m_tdata);

	// stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	// done is always the final result of its input word
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_DONE |-> m_tlast)
		else $error("done without last");

	// error number only on a fatal done
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !(m_tuser == KIND_DONE && od.fatal) |-> od.error_code == 32'sd0)
		else $error("error code outside fatal done");

	// marks cover at least one sector
	a_mark_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_VALID || m_tuser == KIND_HOLE) |-> od.mark_count != 16'd0)
		else $error("empty mark");

	// totals only travel on a done word
	a_totals: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != KIND_DONE |-> od.valid_total == 16'd0 && od.hole_total == 16'd0)
		else $error("totals outside done");

endmodule

bind sector_read_retry_sequencer srrs_checker u_srrs_checker (.*);
`default_nettype wire

/* dv/tb_top.sv */
// self-checking testbench for the sector read retry sequencer: random jobs, retries and holes
`timescale 1ns / 1ps
module tb_top;
	import srrs_pkg::*;

	localparam int unsigned STALL_LIMIT = 1000; // cycles with no word moving on either side
	localparam int unsigned HOLD_CYCLES = 300;  // long receiver hold-off
	localparam int unsigned SETTLE      = 8;    // covers the input register and result buffer with margin

	// one input word as the sender sees it
	typedef struct packed {
		func_t    func;
		in_data_t data;
	} word_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [119:0] s_tdata = '0;  // start_lsn, block_count, rsp_status, rsp_blocks, rsp_error
	logic         s_tuser = 1'b0; // func
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [151:0] m_tdata;        // req_lsn, req_count, first_index, mark_count,
	                              // valid_total, hole_total, fatal, error_code
	logic [1:0]   m_tuser;        // kind
	logic         m_tlast;        // last
	logic         cfg_wr_en = 1'b0;
	logic         cfg_index = 1'b0;
	logic [15:0]  cfg_wdata = '0;

	sector_read_retry_sequencer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// words waiting to be driven, and results the sequencer still owes us
	word_t drive_q[$];
	res_t  due_q[$];

	// run bookkeeping
	int unsigned mismatches = 0;
	int unsigned gen_count = 0;
	int unsigned words_sent = 0;
	int unsigned results_seen = 0;
	int unsigned n_req = 0, n_valid = 0, n_hole = 0, n_done = 0;
	int unsigned settings_used = 0;
	int unsigned idle_cycles = 0;

	// knobs the stimulus process turns
	bit src_idle_en = 1'b1;
	bit sink_idle_en = 1'b1;
	bit hold_req = 1'b0;
	bit job_open = 1'b0; // generator left a job unfinished

	// ------------------------------------------------------------------
	// job predictor: own copy of the registers and job state
	// ------------------------------------------------------------------
	logic [15:0] hole_lim;
	logic [3:0]  retry_lim;
	phase_t      job_ph;
	logic [31:0] job_base;
	logic [15:0] job_len;
	logic [15:0] sec_idx;
	logic [3:0]  tries;     // failed single reads on the current sector
	logic [15:0] good_cnt;
	logic [15:0] hole_cnt;
	res_t        step_out[$];

	function automatic void clear_job_state();
		hole_lim = 16'hFFFF;
		retry_lim = 4'd3;
		job_ph = PH_IDLE;
		job_base = '0;
		job_len = '0;
		sec_idx = '0;
		tries = '0;
		good_cnt = '0;
		hole_cnt = '0;
	endfunction

	function automatic res_t fresh(kind_t k);
		res_t r;
		r = '0;
		r.kind = k;
		return r;
	endfunction

	function automatic void put_req(logic [31:0] lsn, logic [15:0] cnt);
		res_t r;
		r = fresh(KIND_REQ);
		r.data.req_lsn = lsn;
		r.data.req_count = cnt;
		step_out.push_back(r);
	endfunction

	function automatic void put_mark(kind_t k, logic [15:0] first, logic [15:0] cnt);
		res_t r;
		r = fresh(k);
		r.data.first_index = first;
		r.data.mark_count = cnt;
		step_out.push_back(r);
	endfunction

	// job ends: report totals, go idle
	function automatic void end_job(logic is_fatal, logic [31:0] err);
		res_t r;
		r = fresh(KIND_DONE);
		r.data.valid_total = good_cnt;
		r.data.hole_total = hole_cnt;
		r.data.fatal = is_fatal;
		r.data.error_code = is_fatal ? err : 32'd0;
		step_out.push_back(r);
		job_ph = PH_IDLE;
	endfunction

	// ask for the next sector alone, or finish when none are left
	function automatic void next_sector();
		if (sec_idx >= job_len) begin
			end_job(1'b0, 32'd0);
		end else begin
			tries = '0;
			job_ph = PH_SINGLE;
			put_req(job_base + {16'd0, sec_idx}, 16'd1);
		end
	endfunction

	// advance the job by one accepted word and queue what it must produce
	function automatic void apply_word(word_t w);
		in_data_t    d;
		logic [15:0] prefix;
		d = w.data;
		step_out.delete();
		if (w.func == FUNC_START) begin
			// a start always wins, even over a running job
			job_base = d.start_lsn;
			job_len = d.block_count;
			sec_idx = '0;
			tries = '0;
			good_cnt = '0;
			hole_cnt = '0;
			job_ph = PH_BATCH;
			put_req(job_base, job_len);
		end else if (job_ph == PH_BATCH) begin
			// over-reported counts clamp to the job size
			prefix = (d.rsp_blocks > {16'd0, job_len}) ? job_len : d.rsp_blocks[15:0];
			if (prefix != 16'd0) begin
				put_mark(KIND_VALID, 16'd0, prefix);
				good_cnt = prefix;
			end
			if (d.rsp_status) begin
				end_job(1'b1, d.rsp_error);
			end else if (prefix == job_len) begin
				end_job(1'b0, 32'd0);
			end else begin
				sec_idx = prefix;
				next_sector();
			end
		end else if (job_ph == PH_SINGLE) begin
			if (d.rsp_status) begin
				end_job(1'b1, d.rsp_error);
			end else if (d.rsp_blocks == 32'd1) begin
				// only a count of exactly one is a good single read
				put_mark(KIND_VALID, sec_idx, 16'd1);
				good_cnt++;
				sec_idx++;
				next_sector();
			end else if (tries < retry_lim) begin
				tries++;
				put_req(job_base + {16'd0, sec_idx}, 16'd1);
			end else begin
				put_mark(KIND_HOLE, sec_idx, 16'd1);
				hole_cnt++;
				sec_idx++;
				if (hole_cnt >= hole_lim)
					end_job(1'b0, 32'd0);
				else
					next_sector();
			end
		end
		// responses while idle fall through with nothing owed
		if (step_out.size() > 0)
			step_out[step_out.size() - 1].last = 1'b1;
		foreach (step_out[i])
			due_q.push_back(step_out[i]);
	endfunction

	// ------------------------------------------------------------------
	// word builders and job generator
	// ------------------------------------------------------------------
	// unused fields other than pad always carry random bits
	function automatic in_data_t noise_data();
		in_data_t d;
		d = '0;
		d.start_lsn = $urandom;
		d.block_count = 16'($urandom);
		d.rsp_status = 1'($urandom);
		d.rsp_blocks = $urandom;
		d.rsp_error = $urandom;
		return d;
	endfunction

	function automatic word_t start_w(logic [31:0] lsn, logic [15:0] cnt);
		word_t w;
		w.func = FUNC_START;
		w.data = noise_data();
		w.data.start_lsn = lsn;
		w.data.block_count = cnt;
		return w;
	endfunction

	function automatic word_t rsp_w(logic status, logic [31:0] blocks, logic [31:0] err);
		word_t w;
		w.func = FUNC_RSP;
		w.data = noise_data();
		w.data.rsp_status = status;
		w.data.rsp_blocks = blocks;
		w.data.rsp_error = err;
		return w;
	endfunction

	// any single-read count other than one is a failed attempt
	function automatic logic [31:0] miss_blocks();
		logic [31:0] v;
		case ($urandom_range(0, 2))
			0: v = 32'd0;
			1: v = $urandom_range(2, 65535);
			default: v = $urandom;
		endcase
		if (v == 32'd1)
			v = 32'd0;
		return v;
	endfunction

	function automatic void send(word_t w);
		drive_q.push_back(w);
		gen_count++;
	endfunction

	// one well-formed job with random content, sometimes cut short
	function automatic void gen_job();
		int unsigned len, pre, fails, holes;
		logic [31:0] got;
		job_open = 1'b1;
		len = ($urandom_range(0, 15) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
		send(start_w($urandom, len[15:0]));
		if ($urandom_range(0, 15) == 0) begin
			send(rsp_w(1'b1, $urandom, $urandom));
			job_open = 1'b0;
			return;
		end
		case ($urandom_range(0, 3))
			0: got = 32'd0;
			1: got = $urandom_range(0, len);
			2: got = len;
			default: got = $urandom_range(0, 1) ? $urandom : len + $urandom_range(1, 5);
		endcase
		send(rsp_w(1'b0, got, $urandom));
		pre = (got > len) ? len : got;
		holes = 0;
		for (int unsigned i = pre; i < len; i++) begin
			if ($urandom_range(0, 29) == 0) begin
				send(rsp_w(1'b1, $urandom, $urandom));
				job_open = 1'b0;
				return;
			end
			// abandoned: the next start drops it
			if ($urandom_range(0, 29) == 0)
				return;
			case ($urandom_range(0, 2))
				0: fails = retry_lim + 1;
				1: fails = 0;
				default: fails = $urandom_range(0, retry_lim);
			endcase
			repeat (fails) send(rsp_w(1'b0, miss_blocks(), $urandom));
			if (fails > retry_lim) begin
				holes++;
				if (holes >= hole_lim) begin
					job_open = 1'b0;
					return;
				end
			end else begin
				send(rsp_w(1'b0, 32'd1, $urandom));
			end
		end
		job_open = 1'b0;
	endfunction

	// ------------------------------------------------------------------
	// sender: one word on the bus, held until taken
	// ------------------------------------------------------------------
	word_t       on_bus;
	int unsigned src_gap;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			src_gap = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				apply_word(on_bus);
				words_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (src_gap > 0) begin
					src_gap--;
					s_tvalid <= 1'b0;
				end else if (src_idle_en && $urandom_range(0, 5) == 0) begin
					// empty burst, this one included, with src_gap drawn at random
					src_gap = $urandom_range(0, 12);
					s_tvalid <= 1'b0;
				end else if (drive_q.size() > 0) begin
					on_bus = drive_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= on_bus.data;
					s_tuser <= on_bus.func;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// receiver: checks each result against the oldest one owed
	// ------------------------------------------------------------------
	int unsigned sink_gap;
	int unsigned hold_left;

	function automatic void cmp_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t      want;
		out_data_t seen;
		if (!arst_n) begin
			m_tready <= 1'b0;
			sink_gap = 0;
			hold_left = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				seen = m_tdata;
				case (kind_t'(m_tuser))
					KIND_REQ:   n_req++;
					KIND_VALID: n_valid++;
					KIND_HOLE:  n_hole++;
					default:    n_done++;
				endcase
				if (due_q.size() == 0) begin
					$error("result word with nothing owed: kind %0d", m_tuser);
					mismatches++;
				end else begin
					want = due_q.pop_front();
					cmp_field("kind", 32'(want.kind), 32'(m_tuser));
					cmp_field("req_lsn", want.data.req_lsn, seen.req_lsn);
					cmp_field("req_count", 32'(want.data.req_count), 32'(seen.req_count));
					cmp_field("first_index", 32'(want.data.first_index),
						32'(seen.first_index));
					cmp_field("mark_count", 32'(want.data.mark_count), 32'(seen.mark_count));
					cmp_field("valid_total", 32'(want.data.valid_total),
						32'(seen.valid_total));
					cmp_field("hole_total", 32'(want.data.hole_total), 32'(seen.hole_total));
					cmp_field("fatal", 32'(want.data.fatal), 32'(seen.fatal));
					cmp_field("error_code", want.data.error_code, seen.error_code);
					cmp_field("last", 32'(want.last), 32'(m_tlast));
				end
			end
			if (hold_req) begin
				// long hold-off so the result buffer fills and input backs up
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				m_tready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (sink_gap > 0) begin
				sink_gap--;
				m_tready <= 1'b0;
			end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
				sink_gap = $urandom_range(0, 12);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// watchdog: nothing moving for too long means a hang
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("timeout: no word moved for %0d cycles", STALL_LIMIT);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// stimulus sequence
	// ------------------------------------------------------------------
	// sender stays quiet until everything owed has come back
	task automatic wait_drained();
		while (drive_q.size() != 0 || s_tvalid || due_q.size() != 0)
			@(posedge clk);
		// a word that owes nothing may still be in flight
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [15:0] value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		if (idx == CFG_HOLE_CAP)
			hole_lim = value;
		else
			retry_lim = value[3:0];
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic set_limits(logic [15:0] holes, logic [3:0] retries);
		wait_drained();
		write_reg(CFG_HOLE_CAP, holes);
		write_reg(CFG_RETRY_LIMIT, {12'd0, retries});
		settings_used++;
	endtask

	// random jobs with idle responses sprinkled between them
	task automatic run_jobs(int unsigned target);
		int unsigned base;
		base = gen_count;
		while (gen_count - base < target) begin
			gen_job();
			if (!job_open && $urandom_range(0, 9) == 0)
				drive_q.push_back(rsp_w(1'($urandom), $urandom, $urandom));
		end
		// close a cut-short job so the registers change only when idle
		if (job_open) begin
			send(rsp_w(1'b1, $urandom, $urandom));
			job_open = 1'b0;
		end
		wait_drained();
	endtask

	initial begin
		clear_job_state();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty job, then a response with no job running
		send(start_w(32'd0, 16'd0));
		send(rsp_w(1'b0, 32'd0, 32'd0));
		drive_q.push_back(rsp_w(1'b0, 32'd1, 32'h1234_5678));
		// address wrap, retries with odd counts, a hole, then fatal on a single read
		send(start_w(32'hFFFF_FFFE, 16'd4));
		send(rsp_w(1'b0, 32'd1, 32'd0));
		send(rsp_w(1'b0, 32'd1, 32'd0));
		send(rsp_w(1'b0, 32'd2, 32'd0));
		send(rsp_w(1'b0, 32'd0, 32'd0));
		send(rsp_w(1'b0, 32'hFFFF_FFFF, 32'd0));
		send(rsp_w(1'b0, 32'd0, 32'd0));
		send(rsp_w(1'b1, 32'd1, 32'h8000_0000));
		// largest job, drive over-reports
		send(start_w(32'hFFFF_FFFF, 16'hFFFF));
		send(rsp_w(1'b0, 32'hFFFF_FFFF, 32'd0));
		// restart while busy, then fatal batch with a partial prefix
		send(start_w($urandom, 16'd3));
		send(start_w($urandom, 16'd2));
		send(rsp_w(1'b1, 32'd1, 32'h7FFF_FFFF));
		// largest job, fatal batch with nothing read
		send(start_w($urandom, 16'hFFFF));
		send(rsp_w(1'b1, 32'd0, 32'hFFFF_FFFF));
		wait_drained();

		// reset register values, with a long receiver hold-off up front
		settings_used++;
		src_idle_en = 1'b0;
		hold_req = 1'b1;
		run_jobs(65);
		src_idle_en = 1'b1;

		// zero hole limit, no retries
		set_limits(16'd0, 4'd0);
		run_jobs(55);

		// largest hole limit, most retries
		set_limits(16'hFFFF, 4'd15);
		run_jobs(55);

		set_limits(16'd1, 4'd2);
		run_jobs(60);

		set_limits(16'($urandom_range(0, 6)), 4'($urandom_range(0, 5)));
		run_jobs(60);

		// last stretch runs flat out on both sides
		set_limits(16'd2, 4'd1);
		src_idle_en = 1'b0;
		sink_idle_en = 1'b0;
		run_jobs(60);

		$display("covered %0d input words under %0d register settings, %0d results checked",
			words_sent, settings_used, results_seen);
		$display("results: %0d read requests, %0d valid marks, %0d hole marks, %0d job ends",
			n_req, n_valid, n_hole, n_done);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
